FILE: rtl/mwsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwsl_pkg: shared types and constants
// Widths, wheel lane order and the control word that travels down the
// pipeline next to each wheel lane.
// ----------------------------------------------------------------------------
package mwsl_pkg;

  localparam int SPEED_WIDTH_DEFAULT = 16;
  localparam int LIMIT_WIDTH         = 17;
  localparam int WHEEL_WIDTH         = 18;
  localparam int NUM_WHEELS          = 4;
  localparam int DIV_STEPS           = LIMIT_WIDTH;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(2000);

  localparam int WHEEL_FR = 0;
  localparam int WHEEL_FL = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  typedef struct packed {
    logic                  valid;
    logic                  scaled;
    logic [NUM_WHEELS-1:0] neg;
  } mwsl_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/mwsl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwsl_front: wheel mix, magnitude, peak and scale product
// Four register stages: wheel sums, absolute values, pairwise maximum,
// then peak against limit in parallel with magnitude times limit.
// ----------------------------------------------------------------------------
module mwsl_front #(
  parameter int SPEED_WIDTH = mwsl_pkg::SPEED_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [SPEED_WIDTH-1:0]               speed_forward,
  input  wire logic [SPEED_WIDTH-1:0]               speed_sideways,
  input  wire logic [SPEED_WIDTH-1:0]               speed_rotate,
  input  wire logic [mwsl_pkg::LIMIT_WIDTH-1:0]     wheel_speed_limit,
  output mwsl_pkg::mwsl_ctl_t                       out_ctl,
  input  wire logic                                 out_ready,
  output logic [SPEED_WIDTH:0]                      divisor,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] rem_init,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::LIMIT_WIDTH-1:0] dq_init,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::WHEEL_WIDTH-1:0] wrap
);
  import mwsl_pkg::*;

  localparam int SUM_W  = SPEED_WIDTH + 2;
  localparam int MAG_W  = SPEED_WIDTH + 1;
  localparam int PROD_W = MAG_W + LIMIT_WIDTH;
  localparam int CMP_W  = (MAG_W > LIMIT_WIDTH) ? MAG_W : LIMIT_WIDTH;

  logic en_a, en_b, en_c, en_d;

  logic signed [SUM_W-1:0] fwd, side, rot;
  logic signed [SUM_W-1:0] a_sum_next [NUM_WHEELS];

  logic                    a_valid;
  logic signed [SUM_W-1:0] a_sum [NUM_WHEELS];

  logic                    b_valid;
  logic [MAG_W-1:0]        b_mag [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   b_neg;
  logic [WHEEL_WIDTH-1:0]  b_wrap [NUM_WHEELS];

  logic                    c_valid;
  logic [MAG_W-1:0]        c_mag [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   c_neg;
  logic [WHEEL_WIDTH-1:0]  c_wrap [NUM_WHEELS];
  logic [MAG_W-1:0]        c_max01, c_max23;

  logic [MAG_W-1:0]        d_peak_next;
  logic                    d_valid;
  logic                    d_scaled;
  logic [MAG_W-1:0]        d_peak;
  logic [PROD_W-1:0]       d_prod [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   d_neg;
  logic [WHEEL_WIDTH-1:0]  d_wrap [NUM_WHEELS];

  assign en_d     = !d_valid || out_ready;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  assign fwd  = SUM_W'($signed(speed_forward));
  assign side = SUM_W'($signed(speed_sideways));
  assign rot  = SUM_W'($signed(speed_rotate));

  always_comb begin
    a_sum_next[WHEEL_FR] = -fwd - side - rot;
    a_sum_next[WHEEL_FL] =  fwd - side - rot;
    a_sum_next[WHEEL_RL] =  fwd + side - rot;
    a_sum_next[WHEEL_RR] = -fwd + side - rot;
  end

  assign d_peak_next = (c_max01 > c_max23) ? c_max01 : c_max23;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (en_d) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < NUM_WHEELS; i++) a_sum[i] <= a_sum_next[i];
    end
    if (en_b) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        b_mag[i]  <= a_sum[i][SUM_W-1] ? MAG_W'(-a_sum[i]) : MAG_W'(a_sum[i]);
        b_neg[i]  <= a_sum[i][SUM_W-1];
        b_wrap[i] <= WHEEL_WIDTH'(a_sum[i]);
      end
    end
    if (en_c) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        c_mag[i]  <= b_mag[i];
        c_wrap[i] <= b_wrap[i];
      end
      c_neg   <= b_neg;
      c_max01 <= (b_mag[WHEEL_FR] > b_mag[WHEEL_FL]) ? b_mag[WHEEL_FR] : b_mag[WHEEL_FL];
      c_max23 <= (b_mag[WHEEL_RL] > b_mag[WHEEL_RR]) ? b_mag[WHEEL_RL] : b_mag[WHEEL_RR];
    end
    if (en_d) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        d_prod[i] <= PROD_W'(c_mag[i]) * PROD_W'(wheel_speed_limit);
        d_wrap[i] <= c_wrap[i];
      end
      d_neg    <= c_neg;
      d_peak   <= d_peak_next;
      d_scaled <= CMP_W'(d_peak_next) > CMP_W'(wheel_speed_limit);
    end
  end

  always_comb begin
    out_ctl.valid  = d_valid;
    out_ctl.scaled = d_scaled;
    out_ctl.neg    = d_neg;
    divisor        = d_peak;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      rem_init[i] = d_prod[i][PROD_W-1:LIMIT_WIDTH];
      dq_init[i]  = d_prod[i][LIMIT_WIDTH-1:0];
      wrap[i]     = d_wrap[i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mwsl_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwsl_div_step: one restoring divide step for all four wheels
// Shift one dividend bit into the remainder, subtract the shared peak
// when it fits and shift the quotient bit into the low end.
// ----------------------------------------------------------------------------
module mwsl_div_step #(
  parameter int SPEED_WIDTH = mwsl_pkg::SPEED_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mwsl_pkg::mwsl_ctl_t                  in_ctl,
  output logic                                      in_ready,
  input  wire logic [SPEED_WIDTH:0]                 divisor_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] rem_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::LIMIT_WIDTH-1:0] dq_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::WHEEL_WIDTH-1:0] wrap_in,
  output mwsl_pkg::mwsl_ctl_t                       out_ctl,
  input  wire logic                                 out_ready,
  output logic [SPEED_WIDTH:0]                      divisor_out,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] rem_out,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::LIMIT_WIDTH-1:0] dq_out,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::WHEEL_WIDTH-1:0] wrap_out
);
  import mwsl_pkg::*;

  localparam int MAG_W = SPEED_WIDTH + 1;

  logic                                      en;
  logic [MAG_W:0]                            trial [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]                     ge;
  logic [NUM_WHEELS-1:0][MAG_W-1:0]          rem_next;
  logic [NUM_WHEELS-1:0][LIMIT_WIDTH-1:0]    dq_next;

  mwsl_ctl_t                                 ctl_q;
  logic [MAG_W-1:0]                          divisor_q;
  logic [NUM_WHEELS-1:0][MAG_W-1:0]          rem_q;
  logic [NUM_WHEELS-1:0][LIMIT_WIDTH-1:0]    dq_q;
  logic [NUM_WHEELS-1:0][WHEEL_WIDTH-1:0]    wrap_q;

  assign en       = !ctl_q.valid || out_ready;
  assign in_ready = en;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      trial[i]    = {rem_in[i], dq_in[i][LIMIT_WIDTH-1]};
      ge[i]       = trial[i] >= {1'b0, divisor_in};
      rem_next[i] = ge[i] ? MAG_W'(trial[i] - {1'b0, divisor_in}) : MAG_W'(trial[i]);
      dq_next[i]  = {dq_in[i][LIMIT_WIDTH-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q.valid <= 1'b0;
    end else if (en) begin
      ctl_q <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divisor_q <= divisor_in;
      rem_q     <= rem_next;
      dq_q      <= dq_next;
      wrap_q    <= wrap_in;
    end
  end

  assign out_ctl     = ctl_q;
  assign divisor_out = divisor_q;
  assign rem_out     = rem_q;
  assign dq_out      = dq_q;
  assign wrap_out    = wrap_q;

`ifndef SYNTH
  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_chk
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
      ctl_q.valid && (divisor_q != '0) |-> rem_q[g] < divisor_q)
      else $error("divide remainder not below peak");
  end
`endif

endmodule
`default_nettype wire

FILE: rtl/mwsl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwsl_div: pipelined divider chain
// One divide step per register stage, one quotient bit each; the quotient
// leaves in the dq lanes after the last step.
// ----------------------------------------------------------------------------
module mwsl_div #(
  parameter int SPEED_WIDTH = mwsl_pkg::SPEED_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mwsl_pkg::mwsl_ctl_t                  in_ctl,
  output logic                                      in_ready,
  input  wire logic [SPEED_WIDTH:0]                 divisor_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] rem_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::LIMIT_WIDTH-1:0] dq_in,
  input  wire logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::WHEEL_WIDTH-1:0] wrap_in,
  output mwsl_pkg::mwsl_ctl_t                       out_ctl,
  input  wire logic                                 out_ready,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::LIMIT_WIDTH-1:0] quotient,
  output logic [mwsl_pkg::NUM_WHEELS-1:0][mwsl_pkg::WHEEL_WIDTH-1:0] wrap_out
);
  import mwsl_pkg::*;

  mwsl_ctl_t                                 ctl_c     [DIV_STEPS+1];
  logic                                      rdy_c     [DIV_STEPS+1];
  logic [SPEED_WIDTH:0]                      div_c     [DIV_STEPS+1];
  logic [NUM_WHEELS-1:0][SPEED_WIDTH:0]      rem_c     [DIV_STEPS+1];
  logic [NUM_WHEELS-1:0][LIMIT_WIDTH-1:0]    dq_c      [DIV_STEPS+1];
  logic [NUM_WHEELS-1:0][WHEEL_WIDTH-1:0]    wrap_c    [DIV_STEPS+1];

  assign ctl_c[0]  = in_ctl;
  assign div_c[0]  = divisor_in;
  assign rem_c[0]  = rem_in;
  assign dq_c[0]   = dq_in;
  assign wrap_c[0] = wrap_in;
  assign in_ready  = rdy_c[0];

  assign rdy_c[DIV_STEPS] = out_ready;
  assign out_ctl          = ctl_c[DIV_STEPS];
  assign quotient         = dq_c[DIV_STEPS];
  assign wrap_out         = wrap_c[DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    mwsl_div_step #(
      .SPEED_WIDTH (SPEED_WIDTH)
    ) u_step (
      .clk         (clk),
      .rst         (rst),
      .in_ctl      (ctl_c[k]),
      .in_ready    (rdy_c[k]),
      .divisor_in  (div_c[k]),
      .rem_in      (rem_c[k]),
      .dq_in       (dq_c[k]),
      .wrap_in     (wrap_c[k]),
      .out_ctl     (ctl_c[k+1]),
      .out_ready   (rdy_c[k+1]),
      .divisor_out (div_c[k+1]),
      .rem_out     (rem_c[k+1]),
      .dq_out      (dq_c[k+1]),
      .wrap_out    (wrap_c[k+1])
    );
  end

endmodule
`default_nettype wire

FILE: rtl/mecanum_wheel_speed_limiter_core.sv
`default_nettype none
// Pipeline: 4 front stages, 17 divide steps and 1 output register lie between
//   an input beat and its output beat; one restoring divide step per stage.
// Throughput: one command per cycle; a stalled output holds the pipeline
//   back stage by stage, bubbles in front of it still fill.
// Reset: clears all valid bits and loads the wheel speed limit with 2000.
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_limiter_core: mecanum wheel mix with speed limiting
// Forms four wheel speeds from a chassis command and scales all of them by
// limit/peak, truncating toward zero, when the peak exceeds the limit.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_limiter_core #(
  parameter int SPEED_WIDTH = mwsl_pkg::SPEED_WIDTH_DEFAULT
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [mwsl_pkg::LIMIT_WIDTH-1:0]          cfg_data,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // speed_forward, speed_sideways, speed_rotate, zero pad
  input  wire logic [((3*SPEED_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // wheel_front_right, wheel_front_left, wheel_rear_left, wheel_rear_right
  output logic [mwsl_pkg::NUM_WHEELS*mwsl_pkg::WHEEL_WIDTH-1:0] m_axis_tdata,
  // was_scaled
  output logic [0:0]                                     m_axis_tuser
);
  import mwsl_pkg::*;

  logic [LIMIT_WIDTH-1:0]                  wheel_speed_limit;

  mwsl_ctl_t                               f_ctl;
  logic                                    f_ready;
  logic [SPEED_WIDTH:0]                    f_divisor;
  logic [NUM_WHEELS-1:0][SPEED_WIDTH:0]    f_rem;
  logic [NUM_WHEELS-1:0][LIMIT_WIDTH-1:0]  f_dq;
  logic [NUM_WHEELS-1:0][WHEEL_WIDTH-1:0]  f_wrap;

  mwsl_ctl_t                               q_ctl;
  logic [NUM_WHEELS-1:0][LIMIT_WIDTH-1:0]  q_quot;
  logic [NUM_WHEELS-1:0][WHEEL_WIDTH-1:0]  q_wrap;

  logic                                    en_o;
  logic [WHEEL_WIDTH-1:0]                  q_mag [NUM_WHEELS];
  logic [NUM_WHEELS*WHEEL_WIDTH-1:0]       tdata_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_speed_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      wheel_speed_limit <= cfg_data;
    end
  end

  mwsl_front #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .speed_forward     (s_axis_tdata[SPEED_WIDTH-1:0]),
    .speed_sideways    (s_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]),
    .speed_rotate      (s_axis_tdata[3*SPEED_WIDTH-1:2*SPEED_WIDTH]),
    .wheel_speed_limit (wheel_speed_limit),
    .out_ctl           (f_ctl),
    .out_ready         (f_ready),
    .divisor           (f_divisor),
    .rem_init          (f_rem),
    .dq_init           (f_dq),
    .wrap              (f_wrap)
  );

  mwsl_div #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (f_ctl),
    .in_ready   (f_ready),
    .divisor_in (f_divisor),
    .rem_in     (f_rem),
    .dq_in      (f_dq),
    .wrap_in    (f_wrap),
    .out_ctl    (q_ctl),
    .out_ready  (en_o),
    .quotient   (q_quot),
    .wrap_out   (q_wrap)
  );

  assign en_o = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      q_mag[i] = WHEEL_WIDTH'(q_quot[i]);
      if (q_ctl.scaled) begin
        tdata_next[i*WHEEL_WIDTH +: WHEEL_WIDTH] = q_ctl.neg[i] ? -q_mag[i] : q_mag[i];
      end else begin
        tdata_next[i*WHEEL_WIDTH +: WHEEL_WIDTH] = q_wrap[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en_o) begin
      m_axis_tvalid <= q_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      m_axis_tdata    <= tdata_next;
      m_axis_tuser[0] <= q_ctl.scaled;
    end
  end

`ifndef SYNTH
  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_chk
    a_scaled_within_limit: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser[0] |->
        ($signed(m_axis_tdata[g*WHEEL_WIDTH +: WHEEL_WIDTH]) <=
           $signed({2'b00, wheel_speed_limit})) &&
        ($signed(m_axis_tdata[g*WHEEL_WIDTH +: WHEEL_WIDTH]) >=
           -$signed({2'b00, wheel_speed_limit})))
      else $error("scaled wheel speed beyond limit");
  end

  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
